// ===== rtl/fock_moment_evaluator_defines.svh =====
// assertion macros shared by the checker
`ifndef FOCK_MOMENT_EVALUATOR_DEFINES_SVH
`define FOCK_MOMENT_EVALUATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define FME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fme check failed");

// next-cycle implication, off during reset
`define FME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fme check failed");

`endif

// ===== rtl/fme_pkg.sv =====
package fme_pkg;

  localparam int LABEL_W          = 5;
  localparam int IN_TDATA_W       = 8;
  localparam int VALUE_W          = 48;
  localparam int CNT_W            = 7;
  localparam int MODE_W           = 3;
  localparam int MC_W             = 4;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int OCC_STRIDE       = 8;
  localparam int MODES_DEF        = 8;
  localparam int OCC_BITS_DEF     = 8;
  localparam int PRODUCT_BITS_DEF = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPANCY  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_LABEL,
    DP_CLOSE,
    DP_MUL,
    DP_OPEN,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_close;
    logic last;
    logic skip;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/fock_moment_evaluator.sv =====
// Evaluates the expectation value of a product of creation and annihilation
// operators on a Fock state. Each input word carries one operator label
// (0 identity, 2k+1 creation and 2k+2 annihilation of mode k) and tlast marks
// the end of the product; one result word follows each product. Mode count and
// per-mode occupations come from the write port and must only be written while
// the block is idle. A label word is loaded, evaluated and then checked for
// tlast. A word that closes a block first has its counts checked, then makes
// passes through the single 48 x 8 multiplier: n passes for a block of n
// creation/annihilation pairs, none once the block is rejected or the product
// has saturated. The last word of a product then loads the output register,
// waiting for as long as the previous result is still unread. The next
// product's words are taken while a result still waits in that register.
module fock_moment_evaluator
  import fme_pkg::*;
#(
  parameter int MODES        = MODES_DEF,
  parameter int OCC_BITS     = OCC_BITS_DEF,
  parameter int PRODUCT_BITS = PRODUCT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,   // label [4:0], zero fill
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [VALUE_W-1:0]    m_axis_tdata_o,   // moment_value [47:0]
  output logic                  m_axis_tuser_o    // saturated [0]
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  fme_datapath #(
    .MODES        (MODES),
    .OCC_BITS     (OCC_BITS),
    .PRODUCT_BITS (PRODUCT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_label_i  (s_axis_tdata_i[LABEL_W-1:0]),
    .s_last_i   (s_axis_tlast_i),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_value_o  (m_axis_tdata_o),
    .m_sat_o    (m_axis_tuser_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== rtl/fme_ctrl.sv =====
module fme_ctrl
  import fme_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_LAST,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    cmd_o.op  = DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.need_close) begin
          cmd_o.op = DP_CLOSE;
          fin_d    = 1'b0;
          state_d  = S_MUL;
        end else begin
          cmd_o.op = DP_LABEL;
          state_d  = S_LAST;
        end
      end
      S_MUL: begin
        if (status_i.mul_done) begin
          if (fin_q) begin
            state_d = S_OUT;
          end else begin
            // mode changed: start the new block with the held label
            cmd_o.op = DP_OPEN;
            state_d  = S_LAST;
          end
        end else begin
          cmd_o.op = DP_MUL;
        end
      end
      S_LAST: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (!status_i.skip) begin
          cmd_o.op = DP_CLOSE;
          fin_d    = 1'b1;
          state_d  = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = DP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== rtl/fme_datapath.sv =====
module fme_datapath
  import fme_pkg::*;
#(
  parameter int MODES        = MODES_DEF,
  parameter int OCC_BITS     = OCC_BITS_DEF,
  parameter int PRODUCT_BITS = PRODUCT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [LABEL_W-1:0]    s_label_i,
  input  logic                  s_last_i,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output logic [VALUE_W-1:0]    m_value_o,
  output logic                  m_sat_o,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o
);

  localparam int MUL_W = PRODUCT_BITS + OCC_BITS;
  localparam int CMP_W = (OCC_BITS > CNT_W) ? OCC_BITS : CNT_W;
  localparam logic [PRODUCT_BITS-1:0] PROD_MAX = {PRODUCT_BITS{1'b1}};

  // configuration
  logic [MC_W-1:0]       mc_q;
  logic [CFG_DATA_W-1:0] occ_cfg_q;

  // sequence state
  logic [LABEL_W-1:0]      label_q, label_d;
  logic                    last_q, last_d;
  logic                    was_first_q, was_first_d;
  logic                    first_q, first_d;
  logic                    ident_q, ident_d;
  logic                    zero_q, zero_d;
  logic                    sat_q, sat_d;
  logic [MODE_W-1:0]       bm_q, bm_d;
  logic [CNT_W-1:0]        cc_q, cc_d;
  logic [CNT_W-1:0]        ac_q, ac_d;
  logic [PRODUCT_BITS-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [OCC_BITS-1:0]     fac_q, fac_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_sat_q, out_sat_d;

  logic [LABEL_W-1:0]  lbl_m1;
  logic [MC_W-1:0]     mode_k;
  logic [MC_W-1:0]     active;
  logic                in_range;
  logic                skip;
  logic [OCC_BITS-1:0] occ_sel;
  logic [MUL_W-1:0]    mul_full;
  logic                do_open;
  logic                do_count;
  logic [CNT_W-1:0]    cc_base;
  logic [CNT_W-1:0]    ac_base;

  assign lbl_m1   = label_q - LABEL_W'(1);
  assign mode_k   = lbl_m1[LABEL_W-1:1];
  assign active   = (mc_q > MC_W'(MODES)) ? MC_W'(MODES) : mc_q;
  assign in_range = (mode_k < active);
  assign skip     = ident_q | zero_q;
  assign occ_sel  = occ_cfg_q[{bm_q, 3'b000} +: OCC_BITS];
  assign mul_full = MUL_W'(prod_q) * MUL_W'(fac_q);

  assign status_o.need_close = !skip && (label_q != '0) && in_range && !was_first_q &&
                               (mode_k[MODE_W-1:0] != bm_q);
  assign status_o.last       = last_q;
  assign status_o.skip       = skip;
  assign status_o.mul_done   = (rem_q == '0) || sat_q;
  assign status_o.out_busy   = out_valid_q;

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_sat_o   = out_sat_q;

  always_comb begin
    label_d     = label_q;
    last_d      = last_q;
    was_first_d = was_first_q;
    first_d     = first_q;
    ident_d     = ident_q;
    zero_d      = zero_q;
    sat_d       = sat_q;
    bm_d        = bm_q;
    cc_d        = cc_q;
    ac_d        = ac_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    fac_d       = fac_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_sat_d   = out_sat_q;
    do_open     = 1'b0;
    do_count    = 1'b0;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (cmd_i.op)
      DP_LOAD: begin
        label_d     = s_label_i;
        last_d      = s_last_i;
        was_first_d = first_q;
        first_d     = 1'b0;
      end
      DP_LABEL: begin
        if (!skip) begin
          if (label_q == '0) begin
            if (was_first_q) begin
              ident_d = 1'b1;
            end else begin
              zero_d = 1'b1;
            end
          end else if (!in_range) begin
            zero_d = 1'b1;
          end else if (was_first_q) begin
            do_open  = 1'b1;
            do_count = 1'b1;
          end else begin
            do_count = 1'b1;
          end
        end
      end
      DP_CLOSE: begin
        fac_d = occ_sel;
        if ((cc_q != ac_q) || (CMP_W'(cc_q) > CMP_W'(occ_sel))) begin
          zero_d = 1'b1;
          rem_d  = '0;
        end else begin
          rem_d = cc_q;
        end
      end
      DP_MUL: begin
        if (mul_full[MUL_W-1:PRODUCT_BITS] != '0) begin
          prod_d = PROD_MAX;
          sat_d  = 1'b1;
        end else begin
          prod_d = mul_full[PRODUCT_BITS-1:0];
        end
        rem_d = rem_q - CNT_W'(1);
        fac_d = fac_q - OCC_BITS'(1);
      end
      DP_OPEN: begin
        if (!zero_q) begin
          do_open  = 1'b1;
          do_count = 1'b1;
        end
      end
      DP_FINISH: begin
        out_valid_d = 1'b1;
        if (mc_q == '0) begin
          out_value_d = '0;
          out_sat_d   = 1'b0;
        end else if (ident_q) begin
          out_value_d = VALUE_W'(1);
          out_sat_d   = 1'b0;
        end else if (zero_q) begin
          out_value_d = '0;
          out_sat_d   = 1'b0;
        end else begin
          out_value_d = VALUE_W'(prod_q);
          out_sat_d   = sat_q;
        end
        first_d = 1'b1;
        ident_d = 1'b0;
        zero_d  = 1'b0;
        sat_d   = 1'b0;
        bm_d    = '0;
        cc_d    = '0;
        ac_d    = '0;
        prod_d  = PRODUCT_BITS'(1);
      end
      DP_NONE: ;
      default: ;
    endcase

    cc_base = do_open ? '0 : cc_d;
    ac_base = do_open ? '0 : ac_d;
    if (do_open) begin
      bm_d = mode_k[MODE_W-1:0];
      cc_d = '0;
      ac_d = '0;
    end
    if (do_count) begin
      if (label_q[0]) begin
        if (cc_base >= CNT_MAX) begin
          zero_d = 1'b1;
        end else begin
          cc_d = cc_base + CNT_W'(1);
        end
      end else begin
        if (ac_base >= CNT_MAX) begin
          zero_d = 1'b1;
        end else begin
          ac_d = ac_base + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q        <= '0;
      occ_cfg_q   <= '0;
      last_q      <= 1'b0;
      was_first_q <= 1'b0;
      first_q     <= 1'b1;
      ident_q     <= 1'b0;
      zero_q      <= 1'b0;
      sat_q       <= 1'b0;
      bm_q        <= '0;
      cc_q        <= '0;
      ac_q        <= '0;
      prod_q      <= PRODUCT_BITS'(1);
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE_COUNT: mc_q      <= cfg_data_i[MC_W-1:0];
          CFG_OCCUPANCY:  occ_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      last_q      <= last_d;
      was_first_q <= was_first_d;
      first_q     <= first_d;
      ident_q     <= ident_d;
      zero_q      <= zero_d;
      sat_q       <= sat_d;
      bm_q        <= bm_d;
      cc_q        <= cc_d;
      ac_q        <= ac_d;
      prod_q      <= prod_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q     <= label_d;
    fac_q       <= fac_d;
    out_value_q <= out_value_d;
    out_sat_q   <= out_sat_d;
  end

endmodule

// ===== rtl/fme_checker.sv =====
`include "fock_moment_evaluator_defines.svh"

module fme_checker
  import fme_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [VALUE_W-1:0]    m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  // a stalled result word holds
  `FME_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // one word in flight: ready drops right after an accept
  `FME_ASSERT_NEXT(a_one_word, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a clamped product is never reported as zero
  `FME_ASSERT_NOW(a_sat_nonzero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o != '0)

  // results are loaded only while the input side is busy
  `FME_ASSERT_NOW(a_load_busy, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))

endmodule

bind fock_moment_evaluator fme_checker u_fme_checker (.*);
